/* src/omcr_pkg.sv */
// ----------------------------------------------------------------------------
// omcr_pkg
// Shared types and constants of the octree centre-of-mass reduction core.
// ----------------------------------------------------------------------------
package omcr_pkg;

  localparam int unsigned BMASS_W  = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned MASS_W   = 40;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned TOT_W    = 6;
  localparam int unsigned HT_W     = 3;
  localparam int unsigned WACC_W   = 64;
  localparam int unsigned PROD_W   = 72;
  localparam int unsigned MSPLIT   = 20;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned FAN_LOG  = 3;
  localparam int unsigned FAN_RND  = 7;
  localparam int unsigned NUM_W    = 80;
  localparam int unsigned QUO_W    = 31;
  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd80;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [MASS_W-1:0]         mass;
    logic [2:0][POS_W-1:0]     ctr;
  } node_t;

  typedef struct packed {
    logic       ld_in;
    logic       ld_mem;
    logic       ld_zero;
    logic       mul_lo;
    logic       mul_hi;
    logic       sum;
    logic       acc;
    logic       add_mass;
    logic       clr_acc;
    logic       div_start;
    logic       wr_en;
    logic       rd_en;
    logic       out_cap;
    logic       out_ok;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

/* src/omcr_if.sv */
// ----------------------------------------------------------------------------
// omcr_if
// Valid/ready channels of the octree centre-of-mass reduction core.
// ----------------------------------------------------------------------------
interface omcr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [omcr_pkg::BMASS_W-1:0]       body_mass;
  logic signed [omcr_pkg::POS_W-1:0]  pos_x;
  logic signed [omcr_pkg::POS_W-1:0]  pos_y;
  logic signed [omcr_pkg::POS_W-1:0]  pos_z;
  logic                               last_body;
  logic [omcr_pkg::IDX_W-1:0]         node_index;

  modport source (output valid, opcode, body_mass, pos_x, pos_y, pos_z, last_body,
                  node_index, input ready);
  modport sink (input valid, opcode, body_mass, pos_x, pos_y, pos_z, last_body,
                node_index, output ready);
endinterface

interface omcr_out_if;
  logic                               valid;
  logic                               ready;
  logic [omcr_pkg::MASS_W-1:0]        node_mass;
  logic signed [omcr_pkg::POS_W-1:0]  center_x;
  logic signed [omcr_pkg::POS_W-1:0]  center_y;
  logic signed [omcr_pkg::POS_W-1:0]  center_z;
  logic                               node_valid;
  logic [omcr_pkg::TOT_W-1:0]         node_total;
  logic [omcr_pkg::HT_W-1:0]          tree_height;
  logic                               overflowed;

  modport source (output valid, node_mass, center_x, center_y, center_z, node_valid,
                  node_total, tree_height, overflowed, input ready);
  modport sink (input valid, node_mass, center_x, center_y, center_z, node_valid,
                node_total, tree_height, overflowed, output ready);
endinterface

/* src/omcr_datapath.sv */
// ----------------------------------------------------------------------------
// omcr_datapath
// Accumulators, shared multiplier, radix-2 divider and node store.
// ----------------------------------------------------------------------------
module omcr_datapath #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned AW        = $clog2(MAX_NODES)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  omcr_pkg::cmd_t                      cmd_i,
  input  logic [AW-1:0]                       addr_i,
  input  logic [omcr_pkg::BMASS_W-1:0]        body_mass_i,
  input  logic [2:0][omcr_pkg::POS_W-1:0]     pos_i,
  output omcr_pkg::sts_t                      sts_o,
  output omcr_pkg::node_t                     node_o
);

  omcr_pkg::node_t                          mem_q [MAX_NODES];
  omcr_pkg::node_t                          rdata_q;
  omcr_pkg::node_t                          out_q;
  logic [omcr_pkg::MASS_W-1:0]              opm_q;
  logic [2:0][omcr_pkg::POS_W-1:0]          opc_q;
  logic                                     sign_q;
  logic [omcr_pkg::MASS_W+omcr_pkg::MSPLIT-1:0] plo_q;
  logic [omcr_pkg::MASS_W+omcr_pkg::MSPLIT-1:0] phi_q;
  logic [omcr_pkg::PROD_W-1:0]              term_q;
  logic [omcr_pkg::MASS_W-1:0]              macc_q;
  logic [2:0][omcr_pkg::WACC_W-1:0]         wacc_q;
  logic [2:0][omcr_pkg::POS_W-1:0]          ctr_q;

  logic                                     busy_q;
  logic [omcr_pkg::DIV_CNT_W-1:0]           cnt_q;
  logic [omcr_pkg::NUM_W-1:0]               num_q;
  logic [omcr_pkg::MASS_W-1:0]              rem_q;
  logic [omcr_pkg::QUO_W-1:0]               quo_q;
  logic                                     ovf_q;
  logic                                     dneg_q;
  logic [1:0]                               daxis_q;

  logic [omcr_pkg::POS_W-1:0]               opnd;
  logic [omcr_pkg::POS_W-1:0]               amag;
  logic [omcr_pkg::WACC_W-1:0]              term_ext;
  logic [omcr_pkg::MASS_W:0]                msum;
  logic [omcr_pkg::WACC_W-1:0]              wsel;
  logic [omcr_pkg::WACC_W-1:0]              wmag;
  logic [omcr_pkg::MASS_W:0]                r2;
  logic [omcr_pkg::MASS_W:0]                rdiff;
  logic                                     ge;
  logic [omcr_pkg::MASS_W-1:0]              rem_n;
  logic [omcr_pkg::QUO_W-1:0]               quo_n;
  logic                                     ovf_n;
  logic [omcr_pkg::POS_W-1:0]               dres;

  always_comb begin
    opnd     = opc_q[cmd_i.axis];
    amag     = opnd[omcr_pkg::POS_W-1] ? (~opnd + 32'd1) : opnd;
    term_ext = {8'b0, term_q[omcr_pkg::PROD_W-1:omcr_pkg::FRAC_W]};
    msum     = {1'b0, macc_q} + {1'b0, opm_q};
    wsel     = wacc_q[cmd_i.axis];
    wmag     = wsel[omcr_pkg::WACC_W-1] ? (~wsel + 64'd1) : wsel;
    r2       = {rem_q, num_q[omcr_pkg::NUM_W-1]};
    rdiff    = r2 - {1'b0, macc_q};
    ge       = (r2 >= {1'b0, macc_q});
    rem_n    = ge ? rdiff[omcr_pkg::MASS_W-1:0] : r2[omcr_pkg::MASS_W-1:0];
    quo_n    = {quo_q[omcr_pkg::QUO_W-2:0], ge};
    ovf_n    = ovf_q | quo_q[omcr_pkg::QUO_W-1];
    if (macc_q == '0) begin
      dres = '0;
    end else if (dneg_q) begin
      dres = ovf_n ? 32'h8000_0000 : (~{1'b0, quo_n} + 32'd1);
    end else begin
      dres = ovf_n ? 32'h7FFF_FFFF : {1'b0, quo_n};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= omcr_pkg::DIV_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      macc_q <= '0;
      wacc_q <= '0;
    end else if (cmd_i.clr_acc) begin
      macc_q <= '0;
      wacc_q <= '0;
    end else begin
      if (cmd_i.add_mass) begin
        macc_q <= msum[omcr_pkg::MASS_W] ? '1 : msum[omcr_pkg::MASS_W-1:0];
      end
      if (cmd_i.acc) begin
        wacc_q[cmd_i.axis] <= sign_q ? (wsel - term_ext) : (wsel + term_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      opm_q <= {8'b0, body_mass_i};
      opc_q <= pos_i;
    end else if (cmd_i.ld_mem) begin
      opm_q <= rdata_q.mass;
      opc_q <= rdata_q.ctr;
    end else if (cmd_i.ld_zero) begin
      opm_q <= '0;
      opc_q <= '0;
    end
    if (cmd_i.mul_lo) begin
      plo_q  <= 60'(amag * opm_q[omcr_pkg::MSPLIT-1:0]);
      sign_q <= opnd[omcr_pkg::POS_W-1];
    end
    if (cmd_i.mul_hi) begin
      phi_q <= 60'(amag * opm_q[omcr_pkg::MASS_W-1:omcr_pkg::MSPLIT]);
    end
    if (cmd_i.sum) begin
      term_q <= {12'b0, plo_q} + {phi_q[51:0], 20'b0};
    end
    if (cmd_i.div_start) begin
      num_q   <= {wmag, 16'b0};
      rem_q   <= '0;
      quo_q   <= '0;
      ovf_q   <= 1'b0;
      dneg_q  <= wsel[omcr_pkg::WACC_W-1];
      daxis_q <= cmd_i.axis;
    end else if (busy_q) begin
      num_q <= {num_q[omcr_pkg::NUM_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= quo_n;
      ovf_q <= ovf_n;
      if (cnt_q == 7'd1) begin
        ctr_q[daxis_q] <= dres;
      end
    end
    if (cmd_i.wr_en) begin
      mem_q[addr_i] <= '{mass: macc_q, ctr: ctr_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
    if (cmd_i.out_cap) begin
      out_q <= cmd_i.out_ok ? rdata_q : '0;
    end
  end

  assign sts_o.div_busy = busy_q;
  assign node_o         = out_q;

endmodule

/* src/omcr_ctrl.sv */
// ----------------------------------------------------------------------------
// omcr_ctrl
// Sequencer for body loads, leaf flushes, level-by-level build and reads.
// ----------------------------------------------------------------------------
module omcr_ctrl #(
  parameter int unsigned MAX_BODIES    = 256,
  parameter int unsigned LEAF_CAPACITY = 8,
  parameter int unsigned MAX_NODES     = 64,
  parameter int unsigned AW            = $clog2(MAX_NODES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic                          last_body_i,
  input  logic [omcr_pkg::IDX_W-1:0]    node_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          node_valid_o,
  output logic [omcr_pkg::TOT_W-1:0]    node_total_o,
  output logic [omcr_pkg::HT_W-1:0]     tree_height_o,
  output logic                          overflowed_o,
  output omcr_pkg::cmd_t                cmd_o,
  output logic [AW-1:0]                 addr_o,
  input  omcr_pkg::sts_t                sts_i
);

  localparam int unsigned CNT_W  = $clog2(2*MAX_BODIES + MAX_NODES + 64);
  localparam int unsigned BC_W   = $clog2(MAX_BODIES + 1);
  localparam int unsigned FILL_W = $clog2(LEAF_CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MLO, S_MHI, S_SUM, S_ACC, S_DIVGO, S_DIVW, S_WR,
    S_FIN, S_BINIT, S_BSTART, S_BRD, S_BOPND
  } state_e;

  state_e                       state_q;
  logic [1:0]                   axis_q;
  logic                         build_q, last_q, fin_q, drop_q, ov_q, rdok_q, chok_q;
  logic [BC_W-1:0]              body_q;
  logic [FILL_W-1:0]            fill_q;
  logic [CNT_W-1:0]             leaf_q, built_q, poff_q, pcnt_q, ch_q;
  logic [omcr_pkg::HT_W-1:0]    height_q;
  logic                         nv_q, of_q;
  logic [omcr_pkg::TOT_W-1:0]   tot_q;
  logic [omcr_pkg::HT_W-1:0]    ht_q;

  logic                         acc_in;
  logic [CNT_W-1:0]             idx_ext, off, cnt, child, parent, wr_idx;
  logic [CNT_W:0]               sum7;
  logic                         rd_ok, lvl_end, grp_end;

  always_comb begin
    acc_in  = in_valid_i & in_ready_o;
    idx_ext = CNT_W'(node_index_i);
    off     = poff_q + pcnt_q;
    sum7    = {1'b0, pcnt_q} + (CNT_W+1)'(omcr_pkg::FAN_RND);
    cnt     = CNT_W'(sum7 >> omcr_pkg::FAN_LOG);
    child   = poff_q + ch_q;
    parent  = off + (ch_q >> omcr_pkg::FAN_LOG);
    wr_idx  = build_q ? parent : leaf_q;
    lvl_end = (ch_q == pcnt_q - CNT_W'(1));
    grp_end = (ch_q[omcr_pkg::FAN_LOG-1:0] == '1) || lvl_end;
    rd_ok   = (built_q != '0) && (idx_ext < built_q) && (idx_ext < CNT_W'(MAX_NODES));
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    addr_o     = idx_ext[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ld_in = acc_in && (opcode_i == omcr_pkg::OP_LOAD)
                      && (body_q < BC_W'(MAX_BODIES));
        cmd_o.rd_en = acc_in && (opcode_i == omcr_pkg::OP_READ) && rd_ok;
      end
      S_RD: begin
        cmd_o.out_cap = 1'b1;
        cmd_o.out_ok  = rdok_q;
      end
      S_MLO:   cmd_o.mul_lo = 1'b1;
      S_MHI:   cmd_o.mul_hi = 1'b1;
      S_SUM:   cmd_o.sum    = 1'b1;
      S_ACC: begin
        cmd_o.acc      = 1'b1;
        cmd_o.add_mass = (axis_q == 2'd0);
      end
      S_DIVGO: cmd_o.div_start = 1'b1;
      S_WR: begin
        addr_o        = wr_idx[AW-1:0];
        cmd_o.wr_en   = (wr_idx < CNT_W'(MAX_NODES));
        cmd_o.clr_acc = 1'b1;
      end
      S_BRD: begin
        addr_o      = child[AW-1:0];
        cmd_o.rd_en = (child < CNT_W'(MAX_NODES));
      end
      S_BOPND: begin
        cmd_o.ld_mem  = chok_q;
        cmd_o.ld_zero = !chok_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      axis_q   <= '0;
      build_q  <= 1'b0;
      last_q   <= 1'b0;
      fin_q    <= 1'b0;
      drop_q   <= 1'b0;
      ov_q     <= 1'b0;
      rdok_q   <= 1'b0;
      chok_q   <= 1'b0;
      body_q   <= '0;
      fill_q   <= '0;
      leaf_q   <= '0;
      built_q  <= '0;
      poff_q   <= '0;
      pcnt_q   <= '0;
      ch_q     <= '0;
      height_q <= '0;
      nv_q     <= 1'b0;
      of_q     <= 1'b0;
      tot_q    <= '0;
      ht_q     <= '0;
    end else begin
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc_in) begin
            if (opcode_i == omcr_pkg::OP_READ) begin
              rdok_q  <= rd_ok;
              nv_q    <= rd_ok;
              tot_q   <= built_q[omcr_pkg::TOT_W-1:0];
              ht_q    <= height_q;
              of_q    <= drop_q;
              state_q <= S_RD;
            end else begin
              if (built_q != '0) begin
                built_q  <= '0;
                height_q <= '0;
                drop_q   <= 1'b0;
              end
              if (body_q < BC_W'(MAX_BODIES)) begin
                axis_q  <= '0;
                last_q  <= last_body_i;
                state_q <= S_MLO;
              end else begin
                drop_q <= 1'b1;
                if (last_body_i) begin
                  last_q  <= 1'b1;
                  state_q <= S_FIN;
                end
              end
            end
          end
        end
        S_RD: begin
          ov_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        S_MLO: state_q <= S_MHI;
        S_MHI: state_q <= S_SUM;
        S_SUM: state_q <= S_ACC;
        S_ACC: begin
          if (axis_q != 2'd2) begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_MLO;
          end else begin
            axis_q <= '0;
            if (build_q) begin
              if (grp_end) begin
                state_q <= S_DIVGO;
              end else begin
                ch_q    <= ch_q + CNT_W'(1);
                state_q <= S_BRD;
              end
            end else begin
              body_q <= body_q + BC_W'(1);
              if (fill_q == FILL_W'(LEAF_CAPACITY - 1)) begin
                state_q <= S_DIVGO;
              end else begin
                fill_q  <= fill_q + FILL_W'(1);
                state_q <= last_q ? S_FIN : S_IDLE;
              end
            end
          end
        end
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (!sts_i.div_busy) begin
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= S_WR;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_DIVGO;
            end
          end
        end
        S_WR: begin
          if (build_q) begin
            if (lvl_end) begin
              poff_q   <= off;
              pcnt_q   <= cnt;
              height_q <= height_q + 3'd1;
              state_q  <= S_BSTART;
            end else begin
              ch_q    <= ch_q + CNT_W'(1);
              state_q <= S_BRD;
            end
          end else begin
            leaf_q <= leaf_q + CNT_W'(1);
            fill_q <= '0;
            if (fin_q) begin
              state_q <= S_BINIT;
            end else if (last_q) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          fin_q <= 1'b1;
          if (fill_q != '0) begin
            axis_q  <= '0;
            state_q <= S_DIVGO;
          end else begin
            state_q <= S_BINIT;
          end
        end
        S_BINIT: begin
          build_q  <= 1'b1;
          poff_q   <= '0;
          pcnt_q   <= leaf_q;
          height_q <= '0;
          state_q  <= S_BSTART;
        end
        S_BSTART: begin
          if (pcnt_q <= CNT_W'(1)) begin
            built_q <= off;
            body_q  <= '0;
            fill_q  <= '0;
            leaf_q  <= '0;
            last_q  <= 1'b0;
            fin_q   <= 1'b0;
            build_q <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            ch_q    <= '0;
            state_q <= S_BRD;
          end
        end
        S_BRD: begin
          chok_q  <= (child < CNT_W'(MAX_NODES));
          state_q <= S_BOPND;
        end
        S_BOPND: begin
          axis_q  <= '0;
          state_q <= S_MLO;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign node_valid_o  = nv_q;
  assign node_total_o  = tot_q;
  assign tree_height_o = ht_q;
  assign overflowed_o  = of_q;

endmodule

/* src/octree_mass_center_reduction_core.sv */
// ----------------------------------------------------------------------------
// octree_mass_center_reduction_core
// Centre-of-mass tree over Morton-ordered bodies, fixed point Q16.16.
// ----------------------------------------------------------------------------
// Input channel in_i carries load items (opcode 0: one body) and read items
// (opcode 1: one stored node); output channel out_o carries one result per
// read item and none per load.
// A load is accepted, then its three axes pass in turn through the shared
// 32x20 multiplier (S_MLO, S_MHI, S_SUM, S_ACC). Every LEAF_CAPACITY-th
// load, and the last_body load, adds a leaf flush: three 80-step radix-2
// divisions for the centre, then one write to the node store.
// After last_body the tree is built level by level: each child takes a store
// read plus three weighted products, each parent one flush.
// A read loads its node into the read register, then in S_RD into out_o.
// in_i.ready stays low while any of this work runs.
// Reset clears control counters, flags and accumulators: no tree is built and
// reads return node_valid low. The node store is not cleared.
// When out_o stalls the result register holds and in_i.ready stays low for
// every item until the waiting result is taken.
// ----------------------------------------------------------------------------
module octree_mass_center_reduction_core #(
  parameter int unsigned MAX_BODIES    = 256,
  parameter int unsigned LEAF_CAPACITY = 8,
  parameter int unsigned MAX_NODES     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  omcr_in_if.sink     in_i,
  omcr_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  omcr_pkg::cmd_t                  cmd;
  omcr_pkg::sts_t                  sts;
  omcr_pkg::node_t                 node;
  logic [AW-1:0]                   addr;
  logic [2:0][omcr_pkg::POS_W-1:0] pos;

  assign pos = {in_i.pos_z, in_i.pos_y, in_i.pos_x};

  omcr_ctrl #(
    .MAX_BODIES    (MAX_BODIES),
    .LEAF_CAPACITY (LEAF_CAPACITY),
    .MAX_NODES     (MAX_NODES),
    .AW            (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .opcode_i      (in_i.opcode),
    .last_body_i   (in_i.last_body),
    .node_index_i  (in_i.node_index),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .node_valid_o  (out_o.node_valid),
    .node_total_o  (out_o.node_total),
    .tree_height_o (out_o.tree_height),
    .overflowed_o  (out_o.overflowed),
    .cmd_o         (cmd),
    .addr_o        (addr),
    .sts_i         (sts)
  );

  omcr_datapath #(
    .MAX_NODES (MAX_NODES),
    .AW        (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .body_mass_i (in_i.body_mass),
    .pos_i       (pos),
    .sts_o       (sts),
    .node_o      (node)
  );

  assign out_o.node_mass = node.mass;
  assign out_o.center_x  = node.ctr[0];
  assign out_o.center_y  = node.ctr[1];
  assign out_o.center_z  = node.ctr[2];

endmodule

/* src/omcr_checker.sv */
// ----------------------------------------------------------------------------
// omcr_checker
// Port-level checks of the octree centre-of-mass reduction core.
// ----------------------------------------------------------------------------
module omcr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_opcode_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [omcr_pkg::MASS_W-1:0]        node_mass_i,
  input logic [omcr_pkg::POS_W-1:0]         center_x_i,
  input logic [omcr_pkg::POS_W-1:0]         center_y_i,
  input logic [omcr_pkg::POS_W-1:0]         center_z_i,
  input logic                               node_valid_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(node_mass_i)
      && $stable(center_x_i) && $stable(node_valid_i))
    else $error("result item changed while stalled");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == omcr_pkg::OP_READ) |-> ##2 out_valid_i)
    else $error("read item gave no result after two cycles");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == omcr_pkg::OP_READ) |=> !in_ready_i)
    else $error("ready held high while a read is in progress");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !node_valid_i |-> (node_mass_i == '0) && (center_x_i == '0)
      && (center_y_i == '0) && (center_z_i == '0))
    else $error("invalid node read returned nonzero data");

endmodule

bind octree_mass_center_reduction_core omcr_checker u_omcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .node_mass_i  (out_o.node_mass),
  .center_x_i   (out_o.center_x),
  .center_y_i   (out_o.center_y),
  .center_z_i   (out_o.center_z),
  .node_valid_i (out_o.node_valid)
);
